@@ rtl/indexed_sequence_store_assert.svh @@
// assertion macros used by the checker file
// depends on nothing; each macro expands to one labelled concurrent assertion
`ifndef INDEXED_SEQUENCE_STORE_ASSERT_SVH
`define INDEXED_SEQUENCE_STORE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define ISQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("isq assertion failed");

// next-cycle implication, disabled while in reset
`define ISQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("isq assertion failed");

`endif

@@ rtl/isq_pkg.sv @@
// shared types and codes of the indexed sequence store
// depends on nothing; used by the interfaces, the top level and the checker
`timescale 1ns / 1ps
`default_nettype none

package isq_pkg;

    localparam int DEFAULT_CAPACITY = 64;

    localparam int OP_W     = 3;
    localparam int POS_W    = 16;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    typedef logic [OP_W-1:0]          op_t;
    typedef logic [POS_W-1:0]         pos_t;
    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [STATUS_W-1:0]      status_t;
    typedef logic [COUNT_W-1:0]       count_t;

    // operation codes
    localparam op_t OP_READ     = 3'd0;
    localparam op_t OP_INS_HEAD = 3'd1;
    localparam op_t OP_INS_TAIL = 3'd2;
    localparam op_t OP_INS_POS  = 3'd3;
    localparam op_t OP_DELETE   = 3'd4;

    // status codes
    localparam status_t ST_DONE = 2'd0;
    localparam status_t ST_BAD  = 2'd1;
    localparam status_t ST_FULL = 2'd2;

    localparam data_t DATA_NONE = -32'sd1;

endpackage

`default_nettype wire

@@ rtl/isq_if.sv @@
// request and response channel interfaces of the indexed sequence store
// depends on isq_pkg
`timescale 1ns / 1ps
`default_nettype none

interface isq_req_if;
    logic           valid;
    logic           ready;
    isq_pkg::op_t   operation;
    isq_pkg::pos_t  position;
    isq_pkg::data_t item_value;

    modport source (output valid, output operation, output position, output item_value,
                    input ready);
    modport sink (input valid, input operation, input position, input item_value,
                  output ready);
endinterface

interface isq_rsp_if;
    logic             valid;
    logic             ready;
    isq_pkg::data_t   read_value;
    logic             read_valid;
    isq_pkg::status_t status;
    isq_pkg::count_t  entry_count;

    modport source (output valid, output read_value, output read_valid, output status,
                    output entry_count, input ready);
    modport sink (input valid, input read_value, input read_valid, input status,
                  input entry_count, output ready);
endinterface

`default_nettype wire

@@ rtl/isq_ram.sv @@
// generic single-write, single-read ram with registered read data
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

module isq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/indexed_sequence_store.sv @@
// indexed sequence store: ordered list of signed words held in one ram, one request at a time
// a rejected request or read miss goes from S_EXEC to S_FINISH, a read hit through S_RDATA,
// an insert through any S_UP moves and S_PLACE, a delete through any S_DN moves (up to
// CAPACITY-1 moves, one a cycle through the single ram write port); req.ready rises together
// with the response, and a stalled response holds the next result in S_FINISH until it is taken
// reset clears the count and the control state; ram contents are not cleared
`timescale 1ns / 1ps
`default_nettype none

module indexed_sequence_store #(
    parameter int CAPACITY = isq_pkg::DEFAULT_CAPACITY
) (
    input wire logic  clk,
    input wire logic  rst_n,
    isq_req_if.sink   req,
    isq_rsp_if.source rsp
);

    import isq_pkg::*;

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_RDATA  = 3'd2;
    localparam logic [2:0] S_UP     = 3'd3;
    localparam logic [2:0] S_DN     = 3'd4;
    localparam logic [2:0] S_PLACE  = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    logic [2:0]    state_reg, state_next;
    op_t           op_reg, op_next;
    pos_t          pos_reg, pos_next;
    data_t         val_reg, val_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] res_count_reg, res_count_next;
    logic [AW-1:0] k_reg, k_next;
    logic [AW-1:0] p_reg, p_next;
    data_t         rval_reg, rval_next;
    logic          rvalid_reg, rvalid_next;
    status_t       status_reg, status_next;

    logic          out_valid_reg, out_valid_next;
    data_t         out_value_reg, out_value_next;
    logic          out_rvalid_reg, out_rvalid_next;
    status_t       out_status_reg, out_status_next;
    count_t        out_count_reg, out_count_next;

    logic            ram_wr_en;
    logic [AW-1:0]   ram_wr_addr;
    data_t           ram_wr_data;
    logic            ram_rd_en;
    logic [AW-1:0]   ram_rd_addr;
    logic [DATA_W-1:0] ram_rd_data;

    logic [CMPW-1:0] pos_x;
    logic [CMPW-1:0] cnt_x;
    logic [CMPW-1:0] k_x;
    logic [CW-1:0]   ins_tgt;
    logic            full;

    // entry storage
    isq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // operand views for the range checks
    assign pos_x = CMPW'(pos_reg);
    assign cnt_x = CMPW'(count_reg);
    assign k_x   = CMPW'(k_reg);
    assign full  = (count_reg == CAP_CNT);

    // insert target: head, tail or requested position
    always_comb
    begin
        case (op_reg)
            OP_INS_HEAD: ins_tgt = '0;
            OP_INS_TAIL: ins_tgt = count_reg;
            default:     ins_tgt = CW'(pos_reg);
        endcase
    end

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.read_value  = out_value_reg;
    assign rsp.read_valid  = out_rvalid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.entry_count = out_count_reg;

    // sequencer: shifts move one entry a cycle, reading ahead of the write;
    // read and write never hit the same entry in one cycle
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        count_next      = count_reg;
        res_count_next  = res_count_reg;
        k_next          = k_reg;
        p_next          = p_reg;
        rval_next       = rval_reg;
        rvalid_next     = rvalid_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        out_rvalid_next = out_rvalid_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = k_reg;
        ram_wr_data     = data_t'(ram_rd_data);
        ram_rd_en       = 1'b0;
        ram_rd_addr     = k_reg;

        // response taken
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = req.operation;
                    pos_next   = req.position;
                    val_next   = req.item_value;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                rval_next      = '0;
                rvalid_next    = 1'b0;
                status_next    = ST_DONE;
                res_count_next = count_reg;
                state_next     = S_FINISH;
                case (op_reg)
                    OP_READ:
                    begin
                        if (pos_x < cnt_x)
                        begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = AW'(pos_reg);
                            state_next  = S_RDATA;
                        end
                        else
                        begin
                            rval_next   = DATA_NONE;
                            status_next = ST_BAD;
                        end
                    end

                    OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS:
                    begin
                        if (op_reg == OP_INS_POS && pos_x > cnt_x)
                        begin
                            status_next = ST_BAD;
                        end
                        else if (full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            res_count_next = count_reg + CW'(1);
                            p_next         = AW'(ins_tgt);
                            if (ins_tgt == count_reg)
                            begin
                                state_next = S_PLACE;
                            end
                            else
                            begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = AW'(count_reg - CW'(1));
                                k_next      = AW'(count_reg);
                                state_next  = S_UP;
                            end
                        end
                    end

                    OP_DELETE:
                    begin
                        if (pos_x >= cnt_x)
                        begin
                            status_next = ST_BAD;
                        end
                        else
                        begin
                            res_count_next = count_reg - CW'(1);
                            if (pos_x + CMPW'(1) < cnt_x)
                            begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = AW'(pos_x + CMPW'(1));
                                k_next      = AW'(pos_reg);
                                state_next  = S_DN;
                            end
                        end
                    end

                    default:
                    begin
                        status_next = ST_BAD;
                    end
                endcase
            end

            S_RDATA:
            begin
                rval_next   = data_t'(ram_rd_data);
                rvalid_next = 1'b1;
                state_next  = S_FINISH;
            end

            // move entries up one place, from the tail down to the gap
            S_UP:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = k_reg;
                if (k_reg - AW'(1) == p_reg)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = k_reg - AW'(2);
                    k_next      = k_reg - AW'(1);
                end
            end

            // move entries down one place, from the gap to the tail
            S_DN:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = k_reg;
                if (k_x + CMPW'(2) < cnt_x)
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = AW'(k_x + CMPW'(2));
                    k_next      = k_reg + AW'(1);
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end

            // write the new value into the opened gap
            S_PLACE:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = p_reg;
                ram_wr_data = val_reg;
                state_next  = S_FINISH;
            end

            // hand the response over once the output register is free
            S_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = rval_reg;
                    out_rvalid_next = rvalid_reg;
                    out_status_next = status_reg;
                    out_count_next  = COUNT_W'(res_count_reg);
                    count_next      = res_count_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        pos_reg        <= pos_next;
        val_reg        <= val_next;
        res_count_reg  <= res_count_next;
        k_reg          <= k_next;
        p_reg          <= p_next;
        rval_reg       <= rval_next;
        rvalid_reg     <= rvalid_next;
        status_reg     <= status_next;
        out_value_reg  <= out_value_next;
        out_rvalid_reg <= out_rvalid_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

endmodule

`default_nettype wire

@@ rtl/isq_checker.sv @@
// port-level checker for the indexed sequence store, bound to the top level
// depends on isq_pkg and indexed_sequence_store_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "indexed_sequence_store_assert.svh"

module isq_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             rsp_valid,
    input wire logic             rsp_ready,
    input wire isq_pkg::data_t   read_value,
    input wire logic             read_valid,
    input wire isq_pkg::status_t status,
    input wire isq_pkg::count_t  entry_count
);

    import isq_pkg::*;

    // a stalled response holds its contents
    `ISQ_ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(read_value) && $stable(status) && $stable(entry_count))

    // a found entry always comes with a done status
    `ISQ_ASSERT_IMP(a_found_done, clk, rst_n, rsp_valid && read_valid, status == ST_DONE)

    // a refused insert reports no read data
    `ISQ_ASSERT_IMP(a_full_quiet, clk, rst_n, rsp_valid && status == ST_FULL, !read_valid && read_value == '0)

    // a completed non-read carries a zero read value
    `ISQ_ASSERT_IMP(a_done_zero, clk, rst_n, rsp_valid && status == ST_DONE && !read_valid, read_value == '0)

endmodule

bind indexed_sequence_store isq_checker u_isq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .read_value  (rsp.read_value),
    .read_valid  (rsp.read_valid),
    .status      (rsp.status),
    .entry_count (rsp.entry_count)
);

`default_nettype wire
